// ===== design/bsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper package
// Shared codes, register layout types and reset helpers of the mapper.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int PRG_WINDOW_BITS = 13;
    localparam int CHR_WINDOW_BITS = 10;
    localparam int ADDR_WIDTH      = 21;
    localparam int COUNT_WIDTH     = 9;
    localparam int CFG_INDEX_WIDTH = 2;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_CPU_WRITE = 2'd0;
    localparam logic [1:0] OP_CPU_READ  = 2'd1;
    localparam logic [1:0] OP_PPU       = 2'd2;

    // Target codes of a result beat.
    localparam logic [1:0] TGT_NONE      = 2'd0;
    localparam logic [1:0] TGT_PRG_ROM   = 2'd1;
    localparam logic [1:0] TGT_PATTERN   = 2'd2;
    localparam logic [1:0] TGT_NAMETABLE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRG_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHR_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FOUR_SCREEN = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HEADER_VERT = 2'd3;

    // CPU write decode, formed as {address[15:13], address[0]}.
    localparam logic [3:0] WR_CONTROL    = 4'b1000;
    localparam logic [3:0] WR_BANK_DATA  = 4'b1010;
    localparam logic [3:0] WR_MIRROR     = 4'b1001;
    localparam logic [3:0] WR_MIRROR_ALT = 4'b1110;

    localparam logic [7:0] CHR_PAIR_MASK = 8'hFE;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] prg_bank_count;
        logic [COUNT_WIDTH-1:0] chr_bank_count;
        logic                   four_screen;
        logic                   header_vertical;
    } map_cfg_t;

    typedef struct packed {
        logic [7:0]      control;
        logic [1:0][7:0] program_bank;
        logic [5:0][7:0] pattern_bank;
        logic            mirror_vertical;
    } map_state_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] address;
        logic [7:0]  data;
    } wr_cmd_t;

    // Pattern banks after reset or after a new bank count is loaded.
    function automatic logic [5:0][7:0] pattern_reset(input logic [COUNT_WIDTH-1:0] count);
        logic [5:0][7:0] banks;
        banks = '0;
        if (count != '0) begin
            banks[0] = 8'd0;
            banks[1] = 8'd2;
            banks[2] = 8'd4;
            banks[3] = 8'd5;
            banks[4] = 8'd6;
            banks[5] = 8'd7;
        end
        return banks;
    endfunction

endpackage

// ===== design/bsm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper registers
// Configuration registers and the mapper registers written by CPU beats.
// ----------------------------------------------------------------------------
module bsm_regs
    import bsm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COUNT_WIDTH-1:0]     cfg_data,
    input  wr_cmd_t                    wr,
    output map_cfg_t                   cfg,
    output map_state_t                 state
);

    map_cfg_t   cfg_reg, cfg_next;
    map_state_t state_reg, state_next;
    logic [3:0] wr_decode;
    logic [2:0] sel;

    assign wr_decode = {wr.address[15:13], wr.address[0]};
    assign sel       = state_reg.control[2:0];

    always_comb begin
        cfg_next   = cfg_reg;
        state_next = state_reg;

        if (wr.valid) begin
            unique case (wr_decode)
                WR_CONTROL: begin
                    state_next.control = wr.data;
                end
                WR_BANK_DATA: begin
                    if (sel[2:1] == 2'b00) begin
                        state_next.program_bank[sel[0]] = wr.data;
                    end else if (cfg_reg.chr_bank_count != '0) begin
                        // The two 2K banks always start on an even 1K bank.
                        if (sel[2] == 1'b0) begin
                            state_next.pattern_bank[{2'b00, sel[0]}] = wr.data & CHR_PAIR_MASK;
                        end else begin
                            state_next.pattern_bank[3'(sel - 3'd2)] = wr.data;
                        end
                    end
                end
                WR_MIRROR: begin
                    if (!cfg_reg.four_screen) begin
                        state_next.mirror_vertical = wr.data[0];
                    end
                end
                WR_MIRROR_ALT: begin
                    state_next.mirror_vertical = (wr.data == 8'd0);
                end
                default: begin
                end
            endcase
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PRG_COUNT: begin
                    cfg_next.prg_bank_count = cfg_data;
                end
                CFG_CHR_COUNT: begin
                    cfg_next.chr_bank_count   = cfg_data;
                    state_next.pattern_bank   = pattern_reset(cfg_data);
                end
                CFG_FOUR_SCREEN: begin
                    cfg_next.four_screen = cfg_data[0];
                end
                CFG_HEADER_VERT: begin
                    cfg_next.header_vertical    = cfg_data[0];
                    state_next.mirror_vertical  = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prg_bank_count     <= COUNT_WIDTH'(2);
            cfg_reg.chr_bank_count     <= '0;
            cfg_reg.four_screen        <= 1'b0;
            cfg_reg.header_vertical    <= 1'b0;
            state_reg.control          <= '0;
            state_reg.program_bank[0]  <= 8'd0;
            state_reg.program_bank[1]  <= 8'd1;
            state_reg.pattern_bank     <= pattern_reset('0);
            state_reg.mirror_vertical  <= 1'b0;
        end else begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
        end
    end

    assign cfg   = cfg_reg;
    assign state = state_reg;

endmodule

// ===== design/bsm_xlate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper address translation
// Maps a CPU read or PPU access to a target memory and a byte address.
// ----------------------------------------------------------------------------
module bsm_xlate
    import bsm_pkg::*;
(
    input  logic [1:0]            operation,
    input  logic [15:0]           address,
    input  map_cfg_t              cfg,
    input  map_state_t            state,
    output logic [1:0]            target,
    output logic [ADDR_WIDTH-1:0] mapped_address
);

    logic [COUNT_WIDTH-1:0] second_last;
    logic [COUNT_WIDTH-1:0] last;
    logic [COUNT_WIDTH-1:0] prg_bank;
    logic [COUNT_WIDTH-1:0] chr_bank;
    logic [1:0]             prg_win;
    logic [2:0]             chr_win;
    logic                   chr_high;
    logic [11:0]            nt_offset;
    logic                   nt_page;

    always_comb begin
        second_last = cfg.prg_bank_count - COUNT_WIDTH'(2);
        last        = cfg.prg_bank_count - COUNT_WIDTH'(1);
        prg_win     = address[PRG_WINDOW_BITS+1:PRG_WINDOW_BITS];

        unique case (prg_win)
            2'd0:    prg_bank = state.control[6] ? second_last
                                                 : {1'b0, state.program_bank[0]};
            2'd1:    prg_bank = {1'b0, state.program_bank[1]};
            2'd2:    prg_bank = state.control[6] ? {1'b0, state.program_bank[0]}
                                                 : second_last;
            default: prg_bank = last;
        endcase

        // The 2K pair half and the 1K half trade places when control bit 7 is set.
        chr_win  = address[CHR_WINDOW_BITS+2:CHR_WINDOW_BITS];
        chr_high = chr_win[2] ^ state.control[7];
        if (chr_high) begin
            chr_bank = {1'b0, state.pattern_bank[3'({1'b0, chr_win[1:0]} + 3'd2)]};
        end else begin
            chr_bank = {1'b0, state.pattern_bank[{2'b00, chr_win[1]}]}
                       + COUNT_WIDTH'(chr_win[0]);
        end

        nt_offset = address[11:0];
        nt_page   = state.mirror_vertical ? nt_offset[10] : nt_offset[11];

        target         = TGT_NONE;
        mapped_address = '0;
        unique case (operation)
            OP_CPU_READ: begin
                if (address[15]) begin
                    target         = TGT_PRG_ROM;
                    mapped_address = {prg_bank[7:0], address[PRG_WINDOW_BITS-1:0]};
                end
            end
            OP_PPU: begin
                if (!address[13]) begin
                    target = TGT_PATTERN;
                    if (cfg.chr_bank_count == '0) begin
                        mapped_address = ADDR_WIDTH'(address[13:0]);
                    end else begin
                        mapped_address = ADDR_WIDTH'({chr_bank,
                                                      address[CHR_WINDOW_BITS-1:0]});
                    end
                end else if (address[13:8] != 6'h3F) begin
                    target = TGT_NAMETABLE;
                    if (cfg.four_screen) begin
                        mapped_address = ADDR_WIDTH'(nt_offset);
                    end else begin
                        mapped_address = ADDR_WIDTH'({nt_page, nt_offset[9:0]});
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/bank_switch_mapper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper unit
// Cartridge bank mapper: CPU writes set the mapper registers, CPU reads and
// PPU accesses are translated to program ROM, pattern or nametable addresses.
// ----------------------------------------------------------------------------
//  Channel   Ports         Beat content (low bits first)
//  input     s_t*          operation[1:0], address[17:2], data[25:18]
//  result    m_t*          target[1:0], mapped_address[22:2]
//  config    cfg_*         index 0..3, data up to 9 bits, write only
//
// Every input beat gives one result beat. The accepting edge loads the input
// register; the result register is loaded from it through translation once
// the result side is free. A beat is accepted every cycle while results
// are taken. Writes update the mapper registers when the beat leaves the
// input register, so later beats see them. Reset is synchronous and clears
// both stages.
// ----------------------------------------------------------------------------
module bank_switch_mapper_unit
    import bsm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // operation, address, data
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // target, mapped_address
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COUNT_WIDTH-1:0]     cfg_data
);

    logic                  in_valid_reg, in_valid_next;
    logic [1:0]            in_op_reg;
    logic [15:0]           in_addr_reg;
    logic [7:0]            in_data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_target_reg;
    logic [ADDR_WIDTH-1:0] out_addr_reg;

    logic                  out_free;
    logic                  advance;
    logic                  in_take;
    wr_cmd_t               wr;
    map_cfg_t              cfg;
    map_state_t            state;
    logic [1:0]            target;
    logic [ADDR_WIDTH-1:0] mapped_address;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    assign wr.valid   = advance && (in_op_reg == OP_CPU_WRITE);
    assign wr.address = in_addr_reg;
    assign wr.data    = in_data_reg;

    bsm_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (wr),
        .cfg       (cfg),
        .state     (state)
    );

    bsm_xlate u_xlate (
        .operation      (in_op_reg),
        .address        (in_addr_reg),
        .cfg            (cfg),
        .state          (state),
        .target         (target),
        .mapped_address (mapped_address)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg   <= s_tdata[1:0];
            in_addr_reg <= s_tdata[17:2];
            in_data_reg <= s_tdata[25:18];
        end
        if (advance) begin
            out_target_reg <= target;
            out_addr_reg   <= mapped_address;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_addr_reg, out_target_reg};

endmodule

// ===== design/bsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper checker
// Port-level assertions on the mapper unit, bound to the top level.
// ----------------------------------------------------------------------------
module bsm_checker
    import bsm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic [1:0] out_target;

    assign out_target = m_tdata[1:0];

    // A stalled result beat holds its content.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A consumer that is ready never stalls the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while result side is ready");

    // No target means a zero address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_target == TGT_NONE |-> m_tdata[22:2] == '0)
        else $error("address given without a target");

    // Nametable addresses stay within four 1K pages.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_target == TGT_NAMETABLE |-> m_tdata[23:14] == '0)
        else $error("nametable address out of range");

endmodule

bind bank_switch_mapper_unit bsm_checker u_bsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
